### rtl/rkfm_pkg.sv
// Shared constants, codes and control-word types of the Rabin-Karp first-match block.
// Used by every module of the block; depends on nothing.
package rkfm_pkg;

   // sizes
   localparam int MAX_PATTERN = 64;
   localparam int PTR_W       = $clog2(MAX_PATTERN);
   localparam int LEN_W       = PTR_W + 1;
   localparam int HASH_W      = 16;
   localparam int BYTE_W      = 8;
   localparam int RED_W       = HASH_W + BYTE_W;
   localparam int RED_CNT_W   = $clog2(RED_W + 1);
   localparam int CNT_W       = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int STEP_W      = 5;

   // register reset values
   localparam logic [LEN_W-1:0]  LENGTH_RESET  = LEN_W'(1);
   localparam logic [HASH_W-1:0] MODULUS_RESET = HASH_W'(5381);

   // input function codes
   localparam logic FUNC_PATTERN = 1'b0;
   localparam logic FUNC_TEXT    = 1'b1;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LENGTH = 2'd0,
      CSR_HASH_MODULUS   = 2'd1
   } csr_index_type;

   // datapath actions of one control word
   typedef enum logic [4:0] {
      ACT_NOP,
      ACT_FETCH,
      ACT_LD_PH,
      ACT_ITER,
      ACT_WB_PH,
      ACT_LD_LP,
      ACT_WB_LP,
      ACT_TX_START,
      ACT_LD_MUL,
      ACT_WB_SUB,
      ACT_LD_WH,
      ACT_WB_T,
      ACT_LD_WHB,
      ACT_WB_WH,
      ACT_CHECK,
      ACT_RD,
      ACT_CMP,
      ACT_EMIT_FOUND,
      ACT_EMIT_NF,
      ACT_CLR_TEXT
   } act_type;

   // jump conditions
   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_REQ,
      C_TEXT,
      C_RED_RUN,
      C_FIRST,
      C_NO_CHECK,
      C_MISMATCH,
      C_MORE,
      C_OUT_BUSY,
      C_NOT_LAST,
      C_REPORTED
   } cond_type;

   typedef struct packed {
      act_type             act;
      cond_type            cond;
      logic [STEP_W-1:0]   target;
   } ctrl_word_type;

   // status from the datapath, one bit per data-dependent jump condition
   typedef struct packed {
      logic no_req;
      logic text;
      logic red_run;
      logic first;
      logic no_check;
      logic mismatch;
      logic more;
      logic out_busy;
      logic not_last;
      logic reported;
   } flags_type;

endpackage

### rtl/rkfm_if.sv
// Handshake interfaces for the request and response channels of the block.
// Depends on rkfm_pkg for field widths.
interface rkfm_req_if;
   import rkfm_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    func;
   logic [BYTE_W-1:0]       data_byte;
   logic [PTR_W-1:0]        pattern_index;
   logic                    last_text;

   modport source (output valid, func, data_byte, pattern_index, last_text, input ready);
   modport sink   (input valid, func, data_byte, pattern_index, last_text, output ready);
endinterface

interface rkfm_rsp_if;
   import rkfm_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    found;
   logic [CNT_W-1:0]        position;

   modport source (output valid, found, position, input ready);
   modport sink   (input valid, found, position, output ready);
endinterface

### rtl/rkfm_reduce.sv
// Bit-serial modular reduction: operand mod q, one operand bit per step.
// Depends on rkfm_pkg.
module rkfm_reduce (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [rkfm_pkg::HASH_W-1:0]   modulus,
   input  logic                          load,
   input  logic [rkfm_pkg::RED_W-1:0]    operand,
   input  logic                          iter,
   output logic [rkfm_pkg::HASH_W-1:0]   remainder,
   output logic                          running
);
   import rkfm_pkg::*;

   logic [RED_W-1:0]     shift_ff, shift_in;
   logic [HASH_W-1:0]    rem_ff, rem_in;
   logic [RED_CNT_W-1:0] cnt_ff, cnt_in;
   logic [HASH_W:0]      trial;

   // one restoring step: remainder stays below q, so trial stays below 2q
   always_comb begin
      trial    = {rem_ff, shift_ff[RED_W-1]};
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      if (load) begin
         shift_in = operand;
         rem_in   = '0;
         cnt_in   = RED_CNT_W'(RED_W);
      end else if (iter) begin
         shift_in = {shift_ff[RED_W-2:0], 1'b0};
         if (trial >= {1'b0, modulus}) begin
            rem_in = HASH_W'(trial - {1'b0, modulus});
         end else begin
            rem_in = trial[HASH_W-1:0];
         end
         cnt_in = cnt_ff - RED_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign remainder = rem_ff;
   // more steps remain after the current one
   assign running   = (cnt_ff != RED_CNT_W'(1));

endmodule

### rtl/rkfm_useq.sv
// Microcode sequencer: step counter, control-word ROM and conditional jumps.
// Depends on rkfm_pkg.
module rkfm_useq (
   input  logic                     clock,
   input  logic                     reset,
   input  rkfm_pkg::flags_type      flags,
   output rkfm_pkg::ctrl_word_type  ctrl
);
   import rkfm_pkg::*;

   // program labels
   localparam logic [STEP_W-1:0] S_FETCH     = 5'd0;
   localparam logic [STEP_W-1:0] S_DISPATCH  = 5'd1;
   localparam logic [STEP_W-1:0] S_P_LD_PH   = 5'd2;
   localparam logic [STEP_W-1:0] S_P_IT_PH   = 5'd3;
   localparam logic [STEP_W-1:0] S_P_WB_PH   = 5'd4;
   localparam logic [STEP_W-1:0] S_P_LD_LP   = 5'd5;
   localparam logic [STEP_W-1:0] S_P_IT_LP   = 5'd6;
   localparam logic [STEP_W-1:0] S_P_WB_LP   = 5'd7;
   localparam logic [STEP_W-1:0] S_T_START   = 5'd8;
   localparam logic [STEP_W-1:0] S_T_LD_MUL  = 5'd9;
   localparam logic [STEP_W-1:0] S_T_IT_MUL  = 5'd10;
   localparam logic [STEP_W-1:0] S_T_WB_SUB  = 5'd11;
   localparam logic [STEP_W-1:0] S_T_LD_WH   = 5'd12;
   localparam logic [STEP_W-1:0] S_T_IT_WH   = 5'd13;
   localparam logic [STEP_W-1:0] S_T_WB_T    = 5'd14;
   localparam logic [STEP_W-1:0] S_T_ROLL    = 5'd15;
   localparam logic [STEP_W-1:0] S_T_IT_ROLL = 5'd16;
   localparam logic [STEP_W-1:0] S_T_WB_WH   = 5'd17;
   localparam logic [STEP_W-1:0] S_T_CHECK   = 5'd18;
   localparam logic [STEP_W-1:0] S_T_RD      = 5'd19;
   localparam logic [STEP_W-1:0] S_T_CMP     = 5'd20;
   localparam logic [STEP_W-1:0] S_T_MORE    = 5'd21;
   localparam logic [STEP_W-1:0] S_T_FOUND   = 5'd22;
   localparam logic [STEP_W-1:0] S_T_LAST    = 5'd23;
   localparam logic [STEP_W-1:0] S_T_REPCHK  = 5'd24;
   localparam logic [STEP_W-1:0] S_T_NF      = 5'd25;
   localparam logic [STEP_W-1:0] S_T_CLEAR   = 5'd26;

   logic [STEP_W-1:0] step_ff, step_in;
   logic              take;

   // control-word ROM
   always_comb begin
      unique case (step_ff)
         S_FETCH:     ctrl = '{ACT_FETCH,      C_NO_REQ,   S_FETCH};
         S_DISPATCH:  ctrl = '{ACT_NOP,        C_TEXT,     S_T_START};
         S_P_LD_PH:   ctrl = '{ACT_LD_PH,      C_NEVER,    S_FETCH};
         S_P_IT_PH:   ctrl = '{ACT_ITER,       C_RED_RUN,  S_P_IT_PH};
         S_P_WB_PH:   ctrl = '{ACT_WB_PH,      C_NEVER,    S_FETCH};
         S_P_LD_LP:   ctrl = '{ACT_LD_LP,      C_NEVER,    S_FETCH};
         S_P_IT_LP:   ctrl = '{ACT_ITER,       C_RED_RUN,  S_P_IT_LP};
         S_P_WB_LP:   ctrl = '{ACT_WB_LP,      C_ALWAYS,   S_FETCH};
         S_T_START:   ctrl = '{ACT_TX_START,   C_FIRST,    S_T_ROLL};
         S_T_LD_MUL:  ctrl = '{ACT_LD_MUL,     C_NEVER,    S_FETCH};
         S_T_IT_MUL:  ctrl = '{ACT_ITER,       C_RED_RUN,  S_T_IT_MUL};
         S_T_WB_SUB:  ctrl = '{ACT_WB_SUB,     C_NEVER,    S_FETCH};
         S_T_LD_WH:   ctrl = '{ACT_LD_WH,      C_NEVER,    S_FETCH};
         S_T_IT_WH:   ctrl = '{ACT_ITER,       C_RED_RUN,  S_T_IT_WH};
         S_T_WB_T:    ctrl = '{ACT_WB_T,       C_ALWAYS,   S_T_ROLL};
         S_T_ROLL:    ctrl = '{ACT_LD_WHB,     C_NEVER,    S_FETCH};
         S_T_IT_ROLL: ctrl = '{ACT_ITER,       C_RED_RUN,  S_T_IT_ROLL};
         S_T_WB_WH:   ctrl = '{ACT_WB_WH,      C_NEVER,    S_FETCH};
         S_T_CHECK:   ctrl = '{ACT_CHECK,      C_NO_CHECK, S_T_LAST};
         S_T_RD:      ctrl = '{ACT_RD,         C_NEVER,    S_FETCH};
         S_T_CMP:     ctrl = '{ACT_CMP,        C_MISMATCH, S_T_LAST};
         S_T_MORE:    ctrl = '{ACT_NOP,        C_MORE,     S_T_RD};
         S_T_FOUND:   ctrl = '{ACT_EMIT_FOUND, C_OUT_BUSY, S_T_FOUND};
         S_T_LAST:    ctrl = '{ACT_NOP,        C_NOT_LAST, S_FETCH};
         S_T_REPCHK:  ctrl = '{ACT_NOP,        C_REPORTED, S_T_CLEAR};
         S_T_NF:      ctrl = '{ACT_EMIT_NF,    C_OUT_BUSY, S_T_NF};
         S_T_CLEAR:   ctrl = '{ACT_CLR_TEXT,   C_ALWAYS,   S_FETCH};
         default:     ctrl = '{ACT_NOP,        C_ALWAYS,   S_FETCH};
      endcase
   end

   // condition select
   always_comb begin
      unique case (ctrl.cond)
         C_NEVER:    take = 1'b0;
         C_ALWAYS:   take = 1'b1;
         C_NO_REQ:   take = flags.no_req;
         C_TEXT:     take = flags.text;
         C_RED_RUN:  take = flags.red_run;
         C_FIRST:    take = flags.first;
         C_NO_CHECK: take = flags.no_check;
         C_MISMATCH: take = flags.mismatch;
         C_MORE:     take = flags.more;
         C_OUT_BUSY: take = flags.out_busy;
         C_NOT_LAST: take = flags.not_last;
         C_REPORTED: take = flags.reported;
         default:    take = 1'b1;
      endcase
      step_in = take ? ctrl.target : step_ff + STEP_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_FETCH;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

### rtl/rkfm_datapath.sv
// Datapath: hash registers, pattern store, window ring, compare walk and result register.
// Depends on rkfm_pkg, rkfm_if and rkfm_reduce; driven by control words from rkfm_useq.
module rkfm_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [rkfm_pkg::LEN_W-1:0]     len_eff,
   input  logic [rkfm_pkg::HASH_W-1:0]    mod_eff,
   input  rkfm_pkg::ctrl_word_type        ctrl,
   output rkfm_pkg::flags_type            flags,
   rkfm_req_if.sink                       req,
   rkfm_rsp_if.source                     rsp
);
   import rkfm_pkg::*;

   // latched request item
   logic                 func_ff;
   logic [BYTE_W-1:0]    byte_ff;
   logic [PTR_W-1:0]     idx_ff;
   logic                 last_ff;

   // search state
   logic [HASH_W-1:0]    ph_ff, lp_ff, wh_ff, sub_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [PTR_W-1:0]     ptr_ff;
   logic                 mr_ff;
   logic [LEN_W-1:0]     j_ff;

   // stores and their registered read data
   logic [BYTE_W-1:0]    pat_mem  [MAX_PATTERN];
   logic [BYTE_W-1:0]    ring_mem [MAX_PATTERN];
   logic [BYTE_W-1:0]    pat_rd_ff, ring_rd_ff;
   logic [PTR_W-1:0]     ring_raddr;
   logic [LEN_W-1:0]     slot_base, slot_j;

   // result register
   logic                 rsp_valid_ff, rsp_found_ff;
   logic [CNT_W-1:0]     rsp_pos_ff;

   // reduction unit hookup
   logic                 red_load, red_iter, red_running;
   logic [RED_W-1:0]     red_operand;
   logic [HASH_W-1:0]    red_rem;
   logic [HASH_W:0]      diff;
   logic [HASH_W-1:0]    diff_mod;
   logic [CNT_W-1:0]     len_wide;
   logic                 xfer_in, out_free, short_text;

   assign len_wide   = {{(CNT_W-LEN_W){1'b0}}, len_eff};
   assign short_text = (cnt_ff < len_wide);
   assign xfer_in    = req.valid && req.ready;
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign req.ready  = (ctrl.act == ACT_FETCH) && !reset;

   // operand for the reducer
   always_comb begin
      red_load    = 1'b1;
      red_operand = '0;
      case (ctrl.act)
         ACT_LD_PH: begin
            red_operand = (idx_ff == '0) ? {{HASH_W{1'b0}}, byte_ff} : {ph_ff, byte_ff};
         end
         ACT_LD_LP:  red_operand = {lp_ff, {BYTE_W{1'b0}}};
         ACT_LD_MUL: red_operand = RED_W'(lp_ff * ring_rd_ff);
         ACT_LD_WH:  red_operand = {{BYTE_W{1'b0}}, wh_ff};
         ACT_LD_WHB: red_operand = {wh_ff, byte_ff};
         default:    red_load = 1'b0;
      endcase
   end
   assign red_iter = (ctrl.act == ACT_ITER);

   rkfm_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .modulus   (mod_eff),
      .load      (red_load),
      .operand   (red_operand),
      .iter      (red_iter),
      .remainder (red_rem),
      .running   (red_running)
   );

   // (w + q - sub) mod q with both terms already below q
   always_comb begin
      diff = {1'b0, red_rem} + {1'b0, mod_eff} - {1'b0, sub_ff};
      if (diff >= {1'b0, mod_eff}) begin
         diff_mod = HASH_W'(diff - {1'b0, mod_eff});
      end else begin
         diff_mod = diff[HASH_W-1:0];
      end
   end

   // ring read slot: oldest byte of the window, or window byte j
   assign slot_base  = {1'b0, ptr_ff} - len_eff;
   assign slot_j     = slot_base + j_ff;
   assign ring_raddr = (ctrl.act == ACT_RD) ? slot_j[PTR_W-1:0] : slot_base[PTR_W-1:0];

   // stores
   always_ff @(posedge clock) begin
      if (ctrl.act == ACT_WB_PH) begin
         pat_mem[idx_ff] <= byte_ff;
      end
      if (ctrl.act == ACT_WB_WH) begin
         ring_mem[ptr_ff] <= byte_ff;
      end
      ring_rd_ff <= ring_mem[ring_raddr];
      pat_rd_ff  <= pat_mem[j_ff[PTR_W-1:0]];
   end

   // item latch
   always_ff @(posedge clock) begin
      if (xfer_in) begin
         func_ff <= req.func;
         byte_ff <= req.data_byte;
         idx_ff  <= req.pattern_index;
         last_ff <= req.last_text;
      end
   end

   // hash and text state
   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff  <= '0;
         lp_ff  <= HASH_W'(1);
         wh_ff  <= '0;
         cnt_ff <= '0;
         ptr_ff <= '0;
         mr_ff  <= 1'b0;
         j_ff   <= '0;
         sub_ff <= '0;
      end else begin
         case (ctrl.act)
            ACT_WB_PH:  ph_ff  <= red_rem;
            ACT_WB_LP:  lp_ff  <= (idx_ff == '0) ? HASH_W'(1) : red_rem;
            ACT_WB_SUB: sub_ff <= red_rem;
            ACT_WB_T:   wh_ff  <= diff_mod;
            ACT_WB_WH: begin
               wh_ff  <= red_rem;
               ptr_ff <= ptr_ff + PTR_W'(1);
               if (cnt_ff != '1) begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
            end
            ACT_CHECK:  j_ff <= '0;
            ACT_CMP:    j_ff <= j_ff + LEN_W'(1);
            ACT_EMIT_FOUND: begin
               if (out_free) begin
                  mr_ff <= 1'b1;
               end
            end
            ACT_CLR_TEXT: begin
               ptr_ff <= '0;
               wh_ff  <= '0;
               cnt_ff <= '0;
               mr_ff  <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   // result register: frees on transfer, loads on emit
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (out_free && (ctrl.act == ACT_EMIT_FOUND || ctrl.act == ACT_EMIT_NF)) begin
            rsp_valid_ff <= 1'b1;
         end
      end
      if (out_free && ctrl.act == ACT_EMIT_FOUND) begin
         rsp_found_ff <= 1'b1;
         rsp_pos_ff   <= cnt_ff - len_wide;
      end else if (out_free && ctrl.act == ACT_EMIT_NF) begin
         rsp_found_ff <= 1'b0;
         rsp_pos_ff   <= '0;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.found    = rsp_found_ff;
   assign rsp.position = rsp_pos_ff;

   // status for the sequencer
   always_comb begin
      flags.no_req   = !req.valid;
      flags.text     = (func_ff == FUNC_TEXT);
      flags.red_run  = red_running;
      flags.first    = short_text;
      flags.no_check = mr_ff || short_text || (wh_ff != ph_ff);
      flags.mismatch = (ring_rd_ff != pat_rd_ff);
      flags.more     = (j_ff != len_eff);
      flags.out_busy = !out_free;
      flags.not_last = !last_ff;
      flags.reported = mr_ff;
   end

endmodule

### rtl/rabin_karp_first_match_top.sv
// Rabin-Karp first-match search; every reduction runs 24 steps of a bit-serial reducer.
// A pattern byte updates the pattern hash and the power term; a text byte rolls the
// window hash and, on a hash hit, compares the window byte by byte with the pattern.
// One item in flight; the next is taken while a result waits, and an emit stalls until the
// result register is free. Synchronous active-high reset: hashes, counters, length 1 and
// modulus 5381; the pattern store and window ring hold no reset value.
module rabin_karp_first_match_top (
   input  logic                              clock,
   input  logic                              reset,
   rkfm_req_if.sink                          req_chan,
   rkfm_rsp_if.source                        rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [rkfm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rkfm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rkfm_pkg::*;

   logic [LEN_W-1:0]  len_ff;
   logic [HASH_W-1:0] mod_ff;
   logic [LEN_W-1:0]  len_eff;
   logic [HASH_W-1:0] mod_eff;
   ctrl_word_type     ctrl;
   flags_type         flags;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LENGTH_RESET;
         mod_ff <= MODULUS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PATTERN_LENGTH: len_ff <= csr_wdata[LEN_W-1:0];
            CSR_HASH_MODULUS:   mod_ff <= csr_wdata[HASH_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp length to 1..MAX_PATTERN and modulus to at least 2
   always_comb begin
      if (len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (len_ff > LEN_W'(MAX_PATTERN)) begin
         len_eff = LEN_W'(MAX_PATTERN);
      end else begin
         len_eff = len_ff;
      end
      mod_eff = (mod_ff < HASH_W'(2)) ? HASH_W'(2) : mod_ff;
   end

   rkfm_useq u_useq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   rkfm_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .len_eff (len_eff),
      .mod_eff (mod_eff),
      .ctrl    (ctrl),
      .flags   (flags),
      .req     (req_chan),
      .rsp     (rsp_chan)
   );

endmodule
